// ===== src/nfdh_pkg.sv =====
`timescale 1ns / 1ps

package nfdh_pkg;

   // table size and the widths that follow from it
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths
   localparam int DIM_W    = 16;
   localparam int TAG_W    = 7;
   localparam int LEVEL_W  = 6;
   localparam int BOTTOM_W = 22;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_UNDO   = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_PLACE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_INS_HEAD,
      ST_UNDO,
      ST_EMIT_START,
      ST_EMIT,
      ST_STATUS
   } state_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } entry_type;

   // shelf accumulator control
   typedef struct packed {
      logic clear;
      logic step;
   } shelf_ctl_type;

   // placement of the entry being stepped
   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [BOTTOM_W-1:0] bottom;
   } place_type;

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    rect_id;
      logic [DIM_W-1:0]    rect_width;
      logic [DIM_W-1:0]    rect_height;
      logic [LEVEL_W-1:0]  level_index;
      logic [BOTTOM_W-1:0] level_bottom;
      logic                last;
   } rsp_item_type;

endpackage

// ===== src/nfdh_req_if.sv =====
`timescale 1ns / 1ps

interface nfdh_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [nfdh_pkg::DIM_W-1:0]    rect_width_in;
   logic [nfdh_pkg::DIM_W-1:0]    rect_height_in;

   modport source (output valid, command, rect_width_in, rect_height_in, input ready);
   modport sink   (input valid, command, rect_width_in, rect_height_in, output ready);
endinterface

// ===== src/nfdh_rsp_if.sv =====
`timescale 1ns / 1ps

interface nfdh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nfdh_pkg::STATUS_W-1:0]   status;
   logic [nfdh_pkg::TAG_W-1:0]      rect_id;
   logic [nfdh_pkg::DIM_W-1:0]      rect_width_out;
   logic [nfdh_pkg::DIM_W-1:0]      rect_height_out;
   logic [nfdh_pkg::LEVEL_W-1:0]    level_index;
   logic [nfdh_pkg::BOTTOM_W-1:0]   level_bottom;
   logic                            last;

   modport source (output valid, status, rect_id, rect_width_out, rect_height_out,
                   level_index, level_bottom, last, input ready);
   modport sink   (input valid, status, rect_id, rect_width_out, rect_height_out,
                   level_index, level_bottom, last, output ready);
endinterface

// ===== src/nfdh_entry_ram.sv =====
`timescale 1ns / 1ps

module nfdh_entry_ram (
   input  logic                         clock,
   input  logic                         write_en,
   input  logic [nfdh_pkg::IDX_W-1:0]   write_addr,
   input  nfdh_pkg::entry_type          write_data,
   input  logic                         read_en,
   input  logic [nfdh_pkg::IDX_W-1:0]   read_addr,
   output nfdh_pkg::entry_type          read_data
);

   nfdh_pkg::entry_type mem_ff [nfdh_pkg::CAPACITY];
   nfdh_pkg::entry_type read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // registered read port, holds its data while idle
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/nfdh_shelf_acc.sv =====
`timescale 1ns / 1ps

module nfdh_shelf_acc (
   input  logic                         clock,
   input  logic                         reset,
   input  nfdh_pkg::shelf_ctl_type      ctl,
   input  logic [nfdh_pkg::DIM_W-1:0]   strip_width,
   input  logic [nfdh_pkg::DIM_W-1:0]   rect_width,
   input  logic [nfdh_pkg::DIM_W-1:0]   rect_height,
   output nfdh_pkg::place_type          place
);

   logic                            open_ff,    open_in;
   logic [nfdh_pkg::LEVEL_W-1:0]    level_ff,   level_in;
   logic [nfdh_pkg::BOTTOM_W-1:0]   bottom_ff,  bottom_in;
   logic [nfdh_pkg::DIM_W-1:0]      tallest_ff, tallest_in;
   logic [nfdh_pkg::DIM_W-1:0]      sum_ff,     sum_in;

   logic [nfdh_pkg::DIM_W:0]        wide_sum;
   logic                            split;
   logic [nfdh_pkg::DIM_W-1:0]      base_tall;

   // a new shelf opens when the current one is in use and would overflow
   always_comb begin
      wide_sum  = {1'b0, sum_ff} + {1'b0, rect_width};
      split     = open_ff && (wide_sum > {1'b0, strip_width});
      base_tall = split ? '0 : tallest_ff;

      level_in   = split ? level_ff + 1'b1 : level_ff;
      bottom_in  = split ? bottom_ff + nfdh_pkg::BOTTOM_W'(tallest_ff) : bottom_ff;
      tallest_in = (rect_height > base_tall) ? rect_height : base_tall;
      // within a shelf the sum never passes the strip width, so it fits
      sum_in     = split ? rect_width : wide_sum[nfdh_pkg::DIM_W-1:0];
      open_in    = 1'b1;

      place.level  = level_in;
      place.bottom = bottom_in;
   end

   // shelf state
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         open_ff    <= 1'b0;
         level_ff   <= '0;
         bottom_ff  <= '0;
         tallest_ff <= '0;
         sum_ff     <= '0;
      end else if (ctl.step) begin
         open_ff    <= open_in;
         level_ff   <= level_in;
         bottom_ff  <= bottom_in;
         tallest_ff <= tallest_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

// ===== src/nfdh_shelf_packer_unit.sv =====
`timescale 1ns / 1ps

// Shelf packer: keeps up to CAPACITY rectangles sorted by descending height
// (newest first among equal heights) and repacks them into shelves by next fit.
// req_chan takes one command per transfer: insert (width, height) or undo of
// the newest insert. req_chan.ready is high only while no command is in work.
// rsp_chan then gives one result per table entry in table order with its shelf
// number and shelf bottom, last set on the final one; an empty table gives one
// status result, an insert into a full table one reject status result.
// csr_write_en/csr_write_data set the strip width; write it only while idle.
// Sequence of each command, with n entries in the table after the command:
//   insert: a table shift from the tail down to the new entry's slot, then n results
//   undo:   a table walk over every entry from the head, then n results
//   each phase walks the entry memory, one entry per cycle while rsp_chan is ready.
// A stalled rsp_chan holds the current result and pauses the walk.
// Reset empties the table and sets the strip width to 65535; memory contents
// are not cleared, since only entries below the count are ever read.
module nfdh_shelf_packer_unit (
   input  logic                         clock,
   input  logic                         reset,
   nfdh_req_if.sink                     req_chan,
   nfdh_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_en,
   input  logic [nfdh_pkg::DIM_W-1:0]   csr_write_data
);

   localparam int IDX_W = nfdh_pkg::IDX_W;
   localparam int CNT_W = nfdh_pkg::CNT_W;
   localparam int TAG_W = nfdh_pkg::TAG_W;

   nfdh_pkg::state_type              state_ff,   state_in;
   logic [CNT_W-1:0]                 count_ff,   count_in;
   logic [nfdh_pkg::DIM_W-1:0]       strip_ff;
   nfdh_pkg::entry_type              new_ff,     new_in;
   logic [TAG_W-1:0]                 target_ff,  target_in;
   logic [IDX_W-1:0]                 lidx_ff,    lidx_in;
   logic [IDX_W-1:0]                 ridx_ff,    ridx_in;
   logic                             more_ff,    more_in;
   logic                             pend_ff,    pend_in;
   logic [IDX_W-1:0]                 pidx_ff,    pidx_in;
   logic                             found_ff,   found_in;
   logic [IDX_W-1:0]                 eidx_ff,    eidx_in;
   logic [nfdh_pkg::STATUS_W-1:0]    stcode_ff,  stcode_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   nfdh_pkg::rsp_item_type           rsp_item_ff,  rsp_item_in;

   logic                             ram_we;
   logic [IDX_W-1:0]                 ram_waddr;
   nfdh_pkg::entry_type              ram_wdata;
   logic                             ram_re;
   logic [IDX_W-1:0]                 ram_raddr;
   nfdh_pkg::entry_type              ram_rdata;

   nfdh_pkg::shelf_ctl_type          shelf_ctl;
   nfdh_pkg::place_type              place;

   logic                             out_free;
   logic                             emit_last;

   nfdh_entry_ram u_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_en    (ram_re),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   nfdh_shelf_acc u_shelf (
      .clock       (clock),
      .reset       (reset),
      .ctl         (shelf_ctl),
      .strip_width (strip_ff),
      .rect_width  (ram_rdata.width),
      .rect_height (ram_rdata.height),
      .place       (place)
   );

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit_last = (eidx_ff == IDX_W'(count_ff - 1'b1));

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      new_in       = new_ff;
      target_in    = target_ff;
      lidx_in      = lidx_ff;
      ridx_in      = ridx_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      eidx_in      = eidx_ff;
      stcode_in    = stcode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in  = rsp_item_ff;

      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = new_ff;
      ram_re       = 1'b0;
      ram_raddr    = ridx_ff;
      shelf_ctl    = '0;

      req_chan.ready = (state_ff == nfdh_pkg::ST_IDLE);

      case (state_ff)
         nfdh_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.command == nfdh_pkg::CMD_INSERT) begin
                  if (count_ff == CNT_W'(nfdh_pkg::CAPACITY)) begin
                     stcode_in = nfdh_pkg::STATUS_FULL;
                     state_in  = nfdh_pkg::ST_STATUS;
                  end else begin
                     new_in.tag    = TAG_W'(count_ff) + 1'b1;
                     new_in.width  = req_chan.rect_width_in;
                     new_in.height = req_chan.rect_height_in;
                     count_in      = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        // empty table: the new entry goes straight to the head
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = new_in;
                        state_in  = nfdh_pkg::ST_EMIT_START;
                     end else begin
                        ridx_in  = IDX_W'(count_ff - 1'b1);
                        more_in  = 1'b1;
                        pend_in  = 1'b0;
                        state_in = nfdh_pkg::ST_INS;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     stcode_in = nfdh_pkg::STATUS_EMPTY;
                     state_in  = nfdh_pkg::ST_STATUS;
                  end else begin
                     count_in  = count_ff - 1'b1;
                     target_in = TAG_W'(count_ff);
                     lidx_in   = IDX_W'(count_ff - 1'b1);
                     ridx_in   = '0;
                     more_in   = 1'b1;
                     pend_in   = 1'b0;
                     found_in  = 1'b0;
                     if (count_ff == CNT_W'(1)) begin
                        stcode_in = nfdh_pkg::STATUS_EMPTY;
                        state_in  = nfdh_pkg::ST_STATUS;
                     end else begin
                        state_in  = nfdh_pkg::ST_UNDO;
                     end
                  end
               end
            end
         end

         // walk down from the tail, moving each lower entry up one slot
         nfdh_pkg::ST_INS: begin
            ram_re  = more_ff;
            pend_in = more_ff;
            pidx_in = ridx_ff;
            if (more_ff) begin
               ridx_in = ridx_ff - 1'b1;
               more_in = (ridx_ff != '0);
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pidx_ff + 1'b1;
               if (ram_rdata.height > new_ff.height) begin
                  ram_wdata = new_ff;
                  state_in  = nfdh_pkg::ST_EMIT_START;
               end else begin
                  ram_wdata = ram_rdata;
                  if (pidx_ff == '0) begin
                     state_in = nfdh_pkg::ST_INS_HEAD;
                  end
               end
            end
         end

         // every entry moved up: the new one takes the head
         nfdh_pkg::ST_INS_HEAD: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = new_ff;
            state_in  = nfdh_pkg::ST_EMIT_START;
         end

         // walk up from the head, closing the gap behind the newest entry
         nfdh_pkg::ST_UNDO: begin
            ram_re  = more_ff;
            pend_in = more_ff;
            pidx_in = ridx_ff;
            if (more_ff) begin
               ridx_in = ridx_ff + 1'b1;
               more_in = (ridx_ff != lidx_ff);
            end
            if (pend_ff) begin
               if (found_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = pidx_ff - 1'b1;
                  ram_wdata = ram_rdata;
               end
               if (ram_rdata.tag == target_ff) begin
                  found_in = 1'b1;
               end
               if (pidx_ff == lidx_ff) begin
                  state_in = nfdh_pkg::ST_EMIT_START;
               end
            end
         end

         nfdh_pkg::ST_EMIT_START: begin
            ram_re          = 1'b1;
            ram_raddr       = '0;
            shelf_ctl.clear = 1'b1;
            eidx_in         = '0;
            state_in        = nfdh_pkg::ST_EMIT;
         end

         // one placement per cycle while the output register is free
         nfdh_pkg::ST_EMIT: begin
            if (out_free) begin
               shelf_ctl.step           = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = nfdh_pkg::STATUS_PLACE;
               rsp_item_in.rect_id      = ram_rdata.tag;
               rsp_item_in.rect_width   = ram_rdata.width;
               rsp_item_in.rect_height  = ram_rdata.height;
               rsp_item_in.level_index  = place.level;
               rsp_item_in.level_bottom = place.bottom;
               rsp_item_in.last         = emit_last;
               if (emit_last) begin
                  state_in = nfdh_pkg::ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = eidx_ff + 1'b1;
                  eidx_in   = eidx_ff + 1'b1;
               end
            end
         end

         nfdh_pkg::ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in        = '0;
               rsp_item_in.status = stcode_ff;
               rsp_item_in.last   = 1'b1;
               state_in           = nfdh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = nfdh_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfdh_pkg::ST_IDLE;
         count_ff     <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // strip width register
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= '1;
      end else if (csr_write_en) begin
         strip_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      target_ff   <= target_in;
      lidx_ff     <= lidx_in;
      ridx_ff     <= ridx_in;
      pidx_ff     <= pidx_in;
      eidx_ff     <= eidx_in;
      stcode_ff   <= stcode_in;
      rsp_item_ff <= rsp_item_in;
   end

   // result channel
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_item_ff.status;
   assign rsp_chan.rect_id         = rsp_item_ff.rect_id;
   assign rsp_chan.rect_width_out  = rsp_item_ff.rect_width;
   assign rsp_chan.rect_height_out = rsp_item_ff.rect_height;
   assign rsp_chan.level_index     = rsp_item_ff.level_index;
   assign rsp_chan.level_bottom    = rsp_item_ff.level_bottom;
   assign rsp_chan.last            = rsp_item_ff.last;

   // table never grows past its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(nfdh_pkg::CAPACITY))
      else $error("entry count above capacity");

   // a status result always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status != nfdh_pkg::STATUS_PLACE) |-> rsp_item_ff.last)
      else $error("status result without last");

   // an accepted command always starts work
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff != nfdh_pkg::ST_IDLE)
      else $error("command accepted but block stayed idle");

   // a stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("pending result changed under stall");

endmodule
